// ===== src/lpu_pkg.sv =====
// Shared types, constants and helpers of the LCD pixel unpacker.
// Used by every module under src; no dependencies of its own.
package lpu_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ROWS      = PALETTE_DEPTH / 2;
   localparam int PAL_ROW_W     = $clog2(PAL_ROWS);
   localparam int PAL_IDX_W     = $clog2(PALETTE_DEPTH);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TFT_PANEL       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RGB_ORDER       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BYTE_ORDER_BIG  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_ORDER_LSB = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NEWER_VARIANT   = 3'd5;

   // pixel formats
   localparam logic [2:0] MODE_PAL1 = 3'd0;
   localparam logic [2:0] MODE_PAL2 = 3'd1;
   localparam logic [2:0] MODE_PAL4 = 3'd2;
   localparam logic [2:0] MODE_PAL8 = 3'd3;
   localparam logic [2:0] MODE_1555 = 3'd4;
   localparam logic [2:0] MODE_888  = 3'd5;
   localparam logic [2:0] MODE_565  = 3'd6;
   localparam logic [2:0] MODE_444  = 3'd7;

   // input operations
   localparam logic OP_PAL_WRITE = 1'b0;
   localparam logic OP_UNPACK    = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [31:0] data_word;
      logic [6:0]  palette_pair;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] pixel_mode;
      logic       tft_panel;
      logic       rgb_order;
      logic       byte_order_big;
      logic       pixel_order_lsb;
      logic       newer_variant;
   } cfg_type;

   // one pixel on its way from the sequencer to the colour stage
   typedef struct packed {
      logic        is_pal;
      logic        half_hi;
      logic [15:0] raw;
      logic        last;
   } pix_tag_type;

   typedef struct packed {
      logic busy;
      logic issue;
      logic last;
   } seq_stat_type;

   // 1555 to 565: bits 14:5 move up one place, bit 15 lands in bit 5 as green's low bit
   function automatic logic [15:0] widen_1555(input logic [15:0] c);
      return {c[14:5], c[15], c[4:0]};
   endfunction

endpackage

// ===== src/lpu_palette_ram.sv =====
// Palette store: 16-bit entries kept as pairs in 32-bit rows.
// One write port, one registered read port. Uses lpu_pkg.
module lpu_palette_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [lpu_pkg::PAL_ROW_W-1:0] wr_row,
   input  logic [31:0]                   wr_data,
   input  logic                          rd_en,
   input  logic [lpu_pkg::PAL_ROW_W-1:0] rd_row,
   output logic [31:0]                   rd_data
);

   logic [31:0] mem [lpu_pkg::PAL_ROWS];
   logic [31:0] rd_data_ff;

   // read returns the old row on a same-edge write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lpu_unpack_seq.sv =====
// Pixel sequencer: holds one framebuffer word and steps through its pixels,
// issuing one palette read or raw pixel per cycle while adv is high. Uses lpu_pkg.
module lpu_unpack_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  lpu_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   input  lpu_pkg::req_type              req_data,
   output logic                          req_ready,
   input  logic                          adv,
   output logic                          rd_en,
   output logic [lpu_pkg::PAL_ROW_W-1:0] rd_row,
   output lpu_pkg::pix_tag_type          tag,
   output lpu_pkg::seq_stat_type         stat
);

   logic        busy_ff, busy_in;
   logic [31:0] word_ff;
   logic [4:0]  pos_ff;
   logic [4:0]  start_pos, step, sub_flip, flip, amt;
   logic [7:0]  mask;
   logic [31:0] shifted;
   logic [7:0]  idx;
   logic [15:0] half, raw;
   logic        is_pal, use_hi, last_now, issue, accept_word;

   always_comb begin
      unique case (cfg.pixel_mode) inside
         lpu_pkg::MODE_PAL1: begin
            start_pos = 5'd31; step = 5'd1; mask = 8'h01; sub_flip = 5'd7;
         end
         lpu_pkg::MODE_PAL2: begin
            start_pos = 5'd30; step = 5'd2; mask = 8'h03; sub_flip = 5'd6;
         end
         lpu_pkg::MODE_PAL4: begin
            start_pos = 5'd28; step = 5'd4; mask = 8'h0F; sub_flip = 5'd4;
         end
         lpu_pkg::MODE_PAL8: begin
            start_pos = 5'd24; step = 5'd8; mask = 8'hFF; sub_flip = 5'd0;
         end
         lpu_pkg::MODE_1555, lpu_pkg::MODE_565, lpu_pkg::MODE_444: begin
            start_pos = 5'd16; step = 5'd16; mask = 8'h00; sub_flip = 5'd0;
         end
         default: begin
            start_pos = 5'd0; step = 5'd16; mask = 8'h00; sub_flip = 5'd0;
         end
      endcase
   end

   assign is_pal  = (cfg.pixel_mode <= lpu_pkg::MODE_PAL8);
   assign flip    = (cfg.byte_order_big ? 5'd0 : 5'd24) ^
                    (cfg.pixel_order_lsb ? 5'd0 : sub_flip);
   assign amt     = pos_ff ^ flip;
   assign shifted = word_ff >> amt;
   assign idx     = shifted[7:0] & mask;

   // first of two halves is the high one in big-endian order
   assign use_hi = (pos_ff[4] == cfg.byte_order_big);
   assign half   = use_hi ? word_ff[31:16] : word_ff[15:0];

   always_comb begin
      case (cfg.pixel_mode)
         lpu_pkg::MODE_1555: raw = lpu_pkg::widen_1555(half);
         lpu_pkg::MODE_888:  raw = {word_ff[23:19], word_ff[15:10], word_ff[7:3]};
         default:            raw = half;
      endcase
   end

   assign last_now    = (pos_ff == 5'd0);
   assign issue       = busy_ff && adv;
   assign req_ready   = !busy_ff || (adv && last_now);
   assign accept_word = req_valid && req_ready && (req_data.operation == lpu_pkg::OP_UNPACK);

   always_comb begin
      busy_in = busy_ff;
      if (issue && last_now) begin
         busy_in = 1'b0;
      end
      if (accept_word) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_word) begin
         word_ff <= req_data.data_word;
         pos_ff  <= start_pos;
      end else if (issue) begin
         pos_ff <= pos_ff - step;
      end
   end

   assign rd_en   = issue && is_pal;
   assign rd_row  = idx[lpu_pkg::PAL_ROW_W:1];
   assign tag     = '{is_pal: is_pal, half_hi: idx[0], raw: raw, last: last_now};
   assign stat    = '{busy: busy_ff, issue: issue, last: last_now};

endmodule

// ===== src/lpu_colour_conv.sv =====
// Colour stage: takes the palette read data or raw pixel, applies palette
// widening or STN slice and the newer-variant fix-ups, holds the result.
// Uses lpu_pkg.
module lpu_colour_conv (
   input  logic                 clock,
   input  logic                 reset,
   input  lpu_pkg::cfg_type     cfg,
   input  logic                 issue,
   input  lpu_pkg::pix_tag_type tag,
   input  logic [31:0]          rd_data,
   output logic                 adv,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lpu_pkg::rsp_type     rsp_data
);

   logic                 s1_vld_ff;
   lpu_pkg::pix_tag_type s1_ff;
   logic                 rsp_vld_ff;
   lpu_pkg::rsp_type     rsp_ff;
   logic                 rsp_load;
   logic [15:0]          pal16, stn_shifted, pal_pix, base, x444, pix_out;

   assign rsp_load = !rsp_vld_ff || rsp_ready;
   assign adv      = !s1_vld_ff || rsp_load;

   assign pal16       = s1_ff.half_hi ? rd_data[31:16] : rd_data[15:0];
   assign stn_shifted = pal16 >> (cfg.rgb_order ? 4'd11 : 4'd1);
   assign pal_pix     = cfg.tft_panel ? lpu_pkg::widen_1555(pal16)
                                      : {12'd0, stn_shifted[3:0]};
   assign base        = s1_ff.is_pal ? pal_pix : s1_ff.raw;

   always_comb begin
      x444 = base;
      if (cfg.newer_variant && (cfg.pixel_mode == lpu_pkg::MODE_444)) begin
         x444 = {base[11:8], 1'b0, base[7:4], 2'b00, base[3:0], 1'b0};
      end
      pix_out = x444;
      if (cfg.newer_variant && !cfg.rgb_order) begin
         pix_out = {x444[4:0], x444[10:5], x444[15:11]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_vld_ff <= issue;
         end
         if (rsp_load) begin
            rsp_vld_ff <= s1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && issue) begin
         s1_ff <= tag;
      end
      if (rsp_load && s1_vld_ff) begin
         rsp_ff <= '{pixel: pix_out, last: s1_ff.last};
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/lcd_pixel_unpack_rgb565.sv =====
// LCD pixel unpacker: 32-bit framebuffer words in, RGB565 pixels out.
// A pixel is issued from the held word, registered with its palette read in the
// colour stage, then in the output register. One pixel per cycle while the
// output is not stalled, set by the single palette read port; a word gives
// 32/bpp pixels in palette modes, 2 in 1555/565/444, 1 in 888. Reset clears
// config and pipeline only; palette is undefined until written (no clearing pass).
module lcd_pixel_unpack_rgb565 (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lpu_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lpu_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lpu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lpu_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lpu_pkg::cfg_type             cfg_ff;
   lpu_pkg::pix_tag_type         tag;
   lpu_pkg::seq_stat_type        stat;
   logic                         adv, rd_en, pal_wr;
   logic [lpu_pkg::PAL_ROW_W-1:0] rd_row;
   logic [31:0]                  rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pixel_mode: lpu_pkg::MODE_PAL1, tft_panel: 1'b0, rgb_order: 1'b0,
                     byte_order_big: 1'b0, pixel_order_lsb: 1'b0, newer_variant: 1'b1};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lpu_pkg::REG_PIXEL_MODE:      cfg_ff.pixel_mode      <= csr_wdata[2:0];
            lpu_pkg::REG_TFT_PANEL:       cfg_ff.tft_panel       <= csr_wdata[0];
            lpu_pkg::REG_RGB_ORDER:       cfg_ff.rgb_order       <= csr_wdata[0];
            lpu_pkg::REG_BYTE_ORDER_BIG:  cfg_ff.byte_order_big  <= csr_wdata[0];
            lpu_pkg::REG_PIXEL_ORDER_LSB: cfg_ff.pixel_order_lsb <= csr_wdata[0];
            lpu_pkg::REG_NEWER_VARIANT:   cfg_ff.newer_variant   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // a palette write is taken only while the sequencer is idle or issuing its word's last pixel
   assign pal_wr = req_valid && req_ready && (req_data.operation == lpu_pkg::OP_PAL_WRITE);

   lpu_unpack_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .adv       (adv),
      .rd_en     (rd_en),
      .rd_row    (rd_row),
      .tag       (tag),
      .stat      (stat)
   );

   lpu_palette_ram u_ram (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_row  (req_data.palette_pair[lpu_pkg::PAL_ROW_W-1:0]),
      .wr_data (req_data.data_word),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

   lpu_colour_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .issue     (stat.issue),
      .tag       (tag),
      .rd_data   (rd_data),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // no transfer while the sequencer still has pixels of an earlier word to issue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!stat.busy || (stat.issue && stat.last)))
      else $error("input transfer while word still unpacking");

   // a busy sequencer must issue whenever the colour stage can take a pixel
   a_progress: assert property (@(posedge clock) disable iff (reset)
      (stat.busy && adv) |-> stat.issue)
      else $error("sequencer stalled with room downstream");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !stat.busy))
      else $error("pipeline not empty after reset");

endmodule
